// File: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int HEAP_LEVELS_DEF = 12;
   localparam int ADDR_W          = 48;
   localparam int SIZE_W          = 13;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_ADDR_W      = 4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic REG_HEAP_BASE = 1'b0;

   typedef struct packed {
      logic              operation;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic              success;
      logic [ADDR_W-1:0] block_address;
   } rsp_type;

   // smallest k with 2^k >= s
   function automatic logic [3:0] size_log2(input logic [SIZE_W-1:0] s);
      logic [3:0] k;
      k = 4'(SIZE_W);
      for (int i = SIZE_W; i >= 0; i--) begin
         if ((32'(1) << i) >= 32'(s)) begin
            k = 4'(i);
         end
      end
      return k;
   endfunction

endpackage

// File: sv/bba_node_mem.sv
// ----------------------------------------------------------------------------
// bba_node_mem
// Node mark storage: allocated and split bits, one read port, one write port.
// ----------------------------------------------------------------------------
module bba_node_mem #(
   parameter int NODE_W = 13
) (
   input  logic              clock,
   input  logic [NODE_W-1:0] rd_addr,
   output logic              rd_alloc,
   output logic              rd_split,
   input  logic [NODE_W-1:0] wr_addr,
   input  logic              alloc_we,
   input  logic              alloc_wd,
   input  logic              split_we,
   input  logic              split_wd
);

   logic alloc_mem [2**NODE_W];
   logic split_mem [2**NODE_W];

   always_ff @(posedge clock) begin
      if (alloc_we) begin
         alloc_mem[wr_addr] <= alloc_wd;
      end
      if (split_we) begin
         split_mem[wr_addr] <= split_wd;
      end
      rd_alloc <= alloc_mem[rd_addr];
      rd_split <= split_mem[rd_addr];
   end

endmodule

// File: sv/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a heap of 2^HEAP_LEVELS bytes.
// ----------------------------------------------------------------------------
// Usage: req_ carries one item per request (allocate or free), rsp_ returns
// exactly one item for each, in order. heap_base is set over the APB port at
// byte address 0 (64-bit data); the user must write it only while the block
// is idle, as the block itself does not enforce this. After reset a clearing
// pass walks all 2^(HEAP_LEVELS+1) tree nodes, one per cycle, with req_ready
// low; APB stays live. One item is worked on at a time. Node marks live in a
// memory with one read and one write port and a registered read, so every
// tree visit takes a read state and an evaluate state:
//   allocate: a read and evaluate per node visited, backtrack steps in
//             S_A_BACK, then S_A_SET and an S_A_UP step per level up to the root.
//   free:     a read and evaluate per node visited on the way down, then a
//             sibling read and evaluate per level back up to the root.
// Bad sizes and addresses outside the heap go straight to S_DONE.
// The result sits in an output register; when rsp_ready is low a finished
// item waits there and the block still takes the next request, stalling
// only when a second result is ready to leave.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
   parameter int HEAP_LEVELS = bba_pkg::HEAP_LEVELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bba_pkg::req_type                    req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bba_pkg::rsp_type                    rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   import bba_pkg::*;

   localparam int NODE_W = HEAP_LEVELS + 1;
   localparam int LVL_W  = $clog2(HEAP_LEVELS + 1);
   localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);
   localparam logic [LVL_W-1:0]  LEAF = LVL_W'(HEAP_LEVELS);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_A_RD   = 4'd2;
   localparam logic [3:0] S_A_EV   = 4'd3;
   localparam logic [3:0] S_A_BACK = 4'd4;
   localparam logic [3:0] S_A_SET  = 4'd5;
   localparam logic [3:0] S_A_UP   = 4'd6;
   localparam logic [3:0] S_F_RD   = 4'd7;
   localparam logic [3:0] S_F_EV   = 4'd8;
   localparam logic [3:0] S_F_SRD  = 4'd9;
   localparam logic [3:0] S_F_SEV  = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]             state_ff, state_in;
   logic [NODE_W-1:0]      clr_ff, clr_in;
   logic [NODE_W-1:0]      node_ff, node_in;
   logic [LVL_W-1:0]       depth_ff, depth_in;
   logic [LVL_W-1:0]       tgt_ff, tgt_in;
   logic [HEAP_LEVELS-1:0] rel_ff, rel_in;
   logic                   ok_ff, ok_in;
   logic                   cidle_ff, cidle_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [ADDR_W-1:0]      base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [NODE_W-1:0] rd_addr, wr_addr;
   logic              rd_alloc, rd_split;
   logic              alloc_we, alloc_wd, split_we, split_wd;

   logic [LVL_W-1:0]       shamt;
   logic [NODE_W-1:0]      node_low, where_full;
   logic [HEAP_LEVELS:0]   mask_full;
   logic [HEAP_LEVELS-1:0] rel_shift;
   logic [ADDR_W-1:0]      rel_full;
   logic [3:0]             size_k;
   logic                   size_bad;
   logic                   at_start;
   logic                   req_fire, csr_write;

   bba_node_mem #(.NODE_W(NODE_W)) u_mem (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_alloc (rd_alloc),
      .rd_split (rd_split),
      .wr_addr  (wr_addr),
      .alloc_we (alloc_we),
      .alloc_wd (alloc_wd),
      .split_we (split_we),
      .split_wd (split_wd)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[3] == REG_HEAP_BASE) ? CSR_DATA_W'(base_ff) : '0;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign shamt      = LEAF - depth_ff;
   assign node_low   = node_ff ^ (NODE_W'(1) << depth_ff);
   assign where_full = node_low << shamt;
   assign mask_full  = ((HEAP_LEVELS + 1)'(1) << shamt) - (HEAP_LEVELS + 1)'(1);
   assign at_start   = (rel_ff & mask_full[HEAP_LEVELS-1:0]) == '0;
   assign rel_shift  = rel_ff >> (shamt - LVL_W'(1));
   assign rel_full   = req_item.free_address - base_ff;
   assign size_k     = size_log2(req_item.request_size);
   assign size_bad   = (req_item.request_size == '0) ||
                       (32'(req_item.request_size) > (32'(1) << HEAP_LEVELS));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      tgt_in       = tgt_ff;
      rel_in       = rel_ff;
      ok_in        = ok_ff;
      cidle_in     = cidle_ff;
      addr_in      = addr_ff;
      base_in      = csr_write && (paddr[3] == REG_HEAP_BASE) ? pwdata[ADDR_W-1:0] : base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_addr      = node_ff;
      wr_addr      = node_ff;
      alloc_we     = 1'b0;
      alloc_wd     = 1'b0;
      split_we     = 1'b0;
      split_wd     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_addr  = clr_ff;
            alloc_we = 1'b1;
            split_we = 1'b1;
            clr_in   = clr_ff + NODE_W'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               node_in  = ROOT;
               depth_in = '0;
               ok_in    = 1'b0;
               addr_in  = '0;
               tgt_in   = LVL_W'(HEAP_LEVELS - int'(size_k));
               rel_in   = rel_full[HEAP_LEVELS-1:0];
               if (req_item.operation == OP_ALLOC) begin
                  state_in = size_bad ? S_DONE : S_A_RD;
               end else begin
                  state_in = (rel_full[ADDR_W-1:HEAP_LEVELS] != '0) ? S_DONE : S_F_RD;
               end
            end
         end
         S_A_RD: begin
            state_in = S_A_EV;
         end
         S_A_EV: begin
            if (rd_alloc) begin
               state_in = S_A_BACK;
            end else if (depth_ff == tgt_ff) begin
               state_in = rd_split ? S_A_BACK : S_A_SET;
            end else begin
               node_in  = {node_ff[NODE_W-2:0], 1'b0};
               depth_in = depth_ff + LVL_W'(1);
               state_in = S_A_RD;
            end
         end
         S_A_BACK: begin
            if (node_ff == ROOT) begin
               state_in = S_DONE;
            end else if (!node_ff[0]) begin
               node_in  = node_ff + NODE_W'(1);
               state_in = S_A_RD;
            end else begin
               node_in  = node_ff >> 1;
               depth_in = depth_ff - LVL_W'(1);
            end
         end
         S_A_SET: begin
            alloc_we = 1'b1;
            alloc_wd = 1'b1;
            ok_in    = 1'b1;
            addr_in  = base_ff + ADDR_W'(where_full[HEAP_LEVELS-1:0]);
            state_in = (node_ff == ROOT) ? S_DONE : S_A_UP;
         end
         S_A_UP: begin
            wr_addr  = node_ff >> 1;
            split_we = 1'b1;
            split_wd = 1'b1;
            node_in  = node_ff >> 1;
            if ((node_ff >> 1) == ROOT) begin
               state_in = S_DONE;
            end
         end
         S_F_RD: begin
            state_in = S_F_EV;
         end
         S_F_EV: begin
            if (rd_alloc) begin
               if (at_start) begin
                  alloc_we = 1'b1;
                  ok_in    = 1'b1;
               end
               cidle_in = at_start && !rd_split;
               state_in = (node_ff == ROOT) ? S_DONE : S_F_SRD;
            end else if (rd_split && depth_ff != LEAF) begin
               node_in  = {node_ff[NODE_W-2:0], rel_shift[0]};
               depth_in = depth_ff + LVL_W'(1);
               state_in = S_F_RD;
            end else begin
               cidle_in = !rd_split;
               state_in = (node_ff == ROOT) ? S_DONE : S_F_SRD;
            end
         end
         S_F_SRD: begin
            rd_addr  = node_ff ^ NODE_W'(1);
            state_in = S_F_SEV;
         end
         S_F_SEV: begin
            wr_addr = node_ff >> 1;
            if (cidle_ff && !rd_alloc && !rd_split) begin
               split_we = 1'b1;
               cidle_in = 1'b1;
            end else begin
               cidle_in = 1'b0;
            end
            node_in  = node_ff >> 1;
            depth_in = depth_ff - LVL_W'(1);
            state_in = ((node_ff >> 1) == ROOT) ? S_DONE : S_F_SRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.success        = ok_ff;
               rsp_in.block_address  = addr_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff  <= node_in;
      depth_ff <= depth_in;
      tgt_ff   <= tgt_in;
      rel_ff   <= rel_in;
      ok_ff    <= ok_in;
      cidle_ff <= cidle_in;
      addr_ff  <= addr_in;
      rsp_ff   <= rsp_in;
   end

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("request taken during clearing pass");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_EV || state_ff == S_F_EV) |-> depth_ff <= LEAF)
      else $error("tree depth out of range");

   a_node_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_EV || state_ff == S_F_EV) |-> (node_ff >> depth_ff) == ROOT)
      else $error("node index disagrees with depth");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.success |-> rsp_ff.block_address == '0)
      else $error("failed item carries an address");

endmodule
